// ===== sv/btr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types, constants and helpers for the bitmap text renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

  // Default geometry of the glyph store
  localparam int GLYPH_ROWS_DEF = 8;
  localparam int NUM_GLYPHS_DEF = 256;

  localparam int COORD_W   = 16;
  localparam int ROW_IDX_W = 11;
  localparam int Y_W       = 3;   // row counter, glyphs are at most 8 rows tall
  localparam int X_W       = 3;   // bit position inside one row byte
  localparam int BASE_W    = 12;  // code*rows_in_use + top_skip + row fits here

  // APB register map
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam logic [2:0] REG_SCALE     = 3'd0;
  localparam logic [2:0] REG_INK_COLOR = 3'd1;
  localparam logic [2:0] REG_ADVANCE_X = 3'd2;
  localparam logic [2:0] REG_ADVANCE_Y = 3'd3;
  localparam logic [2:0] REG_TOP_SKIP  = 3'd4;
  localparam logic [2:0] REG_MIRRORED  = 3'd5;
  localparam logic [2:0] REG_ROWS      = 3'd6;

  // Register reset values
  localparam logic [3:0] SCALE_RST     = 4'd1;
  localparam logic [7:0] INK_RST       = 8'd255;
  localparam logic [7:0] ADVANCE_X_RST = 8'd8;
  localparam logic [7:0] ADVANCE_Y_RST = 8'd8;
  localparam logic [2:0] TOP_SKIP_RST  = 3'd0;
  localparam logic       MIRRORED_RST  = 1'b0;
  localparam logic [3:0] ROWS_RST      = 4'd8;

  // Input modes and special character codes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ORIGIN = 2'd1;
  localparam logic [1:0] MODE_DRAW   = 2'd2;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ORIGIN,
    OP_NEWLINE,
    OP_SPACE,
    OP_GLYPH
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [7:0]           code;
    logic [ROW_IDX_W-1:0] addr;
    logic [7:0]           bits;
    logic [COORD_W-1:0]   ox;
    logic [COORD_W-1:0]   oy;
  } cmd_t;

  typedef struct packed {
    logic [3:0] scale;
    logic [7:0] ink;
    logic [7:0] adv_x;
    logic [7:0] adv_y;
    logic [2:0] top_skip;
    logic       mirrored;
    logic [3:0] rows;
  } cfg_t;

  typedef struct packed {
    logic busy;        // sequencer is inside a glyph
    logic pend_valid;  // a pixel is held back to learn whether it is the last
  } back_stat_t;

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    r = {b[3:0], b[7:4]};
    r = ((r >> 2) & 8'h33) | ((r << 2) & 8'hcc);
    r = ((r >> 1) & 8'h55) | ((r << 1) & 8'haa);
    return r;
  endfunction

endpackage

// ===== sv/btr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module btr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/btr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_front
// Input side: accepts beats, sorts them into commands and queues them.
// ----------------------------------------------------------------------------
module btr_front #(
  parameter int STORE_DEPTH = btr_pkg::NUM_GLYPHS_DEF * btr_pkg::GLYPH_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic [7:0]                      char_code_i,
  input  logic [btr_pkg::ROW_IDX_W-1:0]   row_index_i,
  input  logic [7:0]                      row_bits_i,
  input  logic [btr_pkg::COORD_W-1:0]     origin_x_i,
  input  logic [btr_pkg::COORD_W-1:0]     origin_y_i,
  output btr_pkg::cmd_t                   cmd_o,
  output logic                            cmd_valid_o,
  input  logic                            cmd_pop_i
);

  localparam logic [btr_pkg::ROW_IDX_W:0] DEPTH_L = (btr_pkg::ROW_IDX_W + 1)'(STORE_DEPTH);

  btr_pkg::cmd_t                  cmd_new;
  logic                           keep;
  logic                           push;
  btr_pkg::cmd_t                  mem_q [btr_pkg::QUEUE_DEPTH];
  logic [btr_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [btr_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [btr_pkg::QCNT_W-1:0]     count_q, count_d;

  // Classify: loads beyond the store and the unused mode are dropped here
  always_comb begin
    cmd_new.code = char_code_i;
    cmd_new.addr = row_index_i;
    cmd_new.bits = row_bits_i;
    cmd_new.ox   = origin_x_i;
    cmd_new.oy   = origin_y_i;
    cmd_new.op   = btr_pkg::OP_GLYPH;
    keep         = 1'b1;
    case (mode_i)
      btr_pkg::MODE_LOAD: begin
        cmd_new.op = btr_pkg::OP_LOAD;
        keep       = ({1'b0, row_index_i} < DEPTH_L);
      end
      btr_pkg::MODE_ORIGIN: begin
        cmd_new.op = btr_pkg::OP_ORIGIN;
      end
      btr_pkg::MODE_DRAW: begin
        if (char_code_i == btr_pkg::CODE_NEWLINE) begin
          cmd_new.op = btr_pkg::OP_NEWLINE;
        end else if (char_code_i == btr_pkg::CODE_SPACE) begin
          cmd_new.op = btr_pkg::OP_SPACE;
        end else begin
          cmd_new.op = btr_pkg::OP_GLYPH;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (count_q != btr_pkg::QCNT_W'(btr_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i & in_ready_o & keep;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == btr_pkg::QPTR_W'(btr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == btr_pkg::QPTR_W'(btr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== sv/btr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_back
// Execution side: glyph store, text cursor and the pixel sequencer.
// ----------------------------------------------------------------------------
module btr_back #(
  parameter int GLYPH_ROWS  = btr_pkg::GLYPH_ROWS_DEF,
  parameter int STORE_DEPTH = btr_pkg::NUM_GLYPHS_DEF * btr_pkg::GLYPH_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  btr_pkg::cfg_t               cfg_i,
  input  btr_pkg::cmd_t               cmd_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [btr_pkg::COORD_W-1:0] pixel_x_o,
  output logic [btr_pkg::COORD_W-1:0] pixel_y_o,
  output logic [7:0]                  pixel_color_o,
  output logic                        last_o,
  output btr_pkg::back_stat_t         stat_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = btr_pkg::COORD_W;
  localparam int BW = btr_pkg::BASE_W;
  localparam int REDUCE_STEPS =
    $clog2(((1 << BW) + STORE_DEPTH - 1) / STORE_DEPTH) > 0 ?
    $clog2(((1 << BW) + STORE_DEPTH - 1) / STORE_DEPTH) : 1;
  localparam logic [3:0] ROWS_MAX = 4'(GLYPH_ROWS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [CW-1:0]              line_x_q, line_x_d, line_y_q, line_y_d;
  logic [CW-1:0]              cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [BW-1:0]              base_q, base_d;
  logic [AW-1:0]              addr_q, addr_d;
  logic [btr_pkg::Y_W-1:0]    y_q, y_d;
  logic [7:0]                 mask_q, mask_d;
  logic                       pend_valid_q, pend_valid_d;
  logic [CW-1:0]              pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic                       out_valid_q, out_valid_d;
  logic [CW-1:0]              out_x_q, out_x_d, out_y_q, out_y_d;
  logic [7:0]                 out_color_q, out_color_d;
  logic                       out_last_q, out_last_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [7:0]                 ram_rdata;
  logic [3:0]                 rows_eff;
  logic [11:0]                adv_x_s, adv_y_s;
  logic [BW:0]                red_v;
  logic [btr_pkg::X_W-1:0]    xi;
  logic [6:0]                 sx, sy;
  logic [CW-1:0]              cand_x, cand_y;
  logic                       out_free;
  logic [AW:0]                addr_inc;

  btr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.bits),
    .rdata_o (ram_rdata)
  );

  assign rows_eff = (cfg_i.rows > ROWS_MAX) ? ROWS_MAX : cfg_i.rows;
  assign adv_x_s  = cfg_i.scale * cfg_i.adv_x;
  assign adv_y_s  = cfg_i.scale * cfg_i.adv_y;
  assign out_free = !out_valid_q || out_ready_i;
  assign addr_inc = {1'b0, addr_q} + 1'b1;

  // Start row modulo the store depth, one compare-subtract per power of two
  always_comb begin
    red_v = {1'b0, base_q};
    for (int k = REDUCE_STEPS - 1; k >= 0; k--) begin
      if (red_v >= ((BW + 1)'(STORE_DEPTH) << k)) begin
        red_v = red_v - ((BW + 1)'(STORE_DEPTH) << k);
      end
    end
  end

  // Leftmost remaining dot of the row
  always_comb begin
    xi = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_q[7 - i]) begin
        xi = btr_pkg::X_W'(i);
      end
    end
  end

  assign sx     = cfg_i.scale * xi;
  assign sy     = cfg_i.scale * y_q;
  assign cand_x = cur_x_q + {{(CW - 7){1'b0}}, sx};
  assign cand_y = cur_y_q + {{(CW - 7){1'b0}}, sy};

  always_comb begin
    state_d      = state_q;
    line_x_d     = line_x_q;
    line_y_d     = line_y_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    base_d       = base_q;
    addr_d       = addr_q;
    y_d          = y_q;
    mask_d       = mask_q;
    pend_valid_d = pend_valid_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = addr_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            btr_pkg::OP_LOAD: begin
              ram_we   = 1'b1;
              ram_addr = cmd_i.addr[AW-1:0];
            end
            btr_pkg::OP_ORIGIN: begin
              line_x_d = cmd_i.ox;
              line_y_d = cmd_i.oy;
              cur_x_d  = cmd_i.ox;
              cur_y_d  = cmd_i.oy;
            end
            btr_pkg::OP_NEWLINE: begin
              line_y_d = line_y_q + {{(CW - 12){1'b0}}, adv_y_s};
              cur_x_d  = line_x_q;
              cur_y_d  = line_y_q + {{(CW - 12){1'b0}}, adv_y_s};
            end
            btr_pkg::OP_SPACE: begin
              cur_x_d = cur_x_q + {{(CW - 12){1'b0}}, adv_x_s};
            end
            btr_pkg::OP_GLYPH: begin
              base_d  = BW'({4'd0, cmd_i.code} * {8'd0, cfg_i.rows}) + BW'(cfg_i.top_skip);
              state_d = S_REDUCE;
            end
            default: ;
          endcase
        end
      end

      S_REDUCE: begin
        addr_d  = red_v[AW-1:0];
        y_d     = '0;
        state_d = (rows_eff == '0) ? S_FINISH : S_READ;
      end

      S_READ: begin
        state_d = S_LOAD;
      end

      S_LOAD: begin
        mask_d  = cfg_i.mirrored ? btr_pkg::reverse8(ram_rdata) : ram_rdata;
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (mask_q != '0) begin
          // Hold one pixel back so the final one of the glyph can be flagged
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_x_d     = pend_x_q;
              out_y_d     = pend_y_q;
              out_color_d = cfg_i.ink;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_x_d     = cand_x;
            pend_y_d     = cand_y;
            mask_d       = mask_q & ~(8'h80 >> xi);
          end
        end else if (({1'b0, y_q} + 4'd1) < rows_eff) begin
          y_d     = y_q + 1'b1;
          addr_d  = (addr_inc == (AW + 1)'(STORE_DEPTH)) ? '0 : addr_inc[AW-1:0];
          state_d = S_READ;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_x_d      = pend_x_q;
            out_y_d      = pend_y_q;
            out_color_d  = cfg_i.ink;
            out_last_d   = 1'b1;
            pend_valid_d = 1'b0;
          end
          cur_x_d = cur_x_q + {{(CW - 12){1'b0}}, adv_x_s};
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      line_x_q     <= '0;
      line_y_q     <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      line_x_q     <= line_x_d;
      line_y_q     <= line_y_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    addr_q      <= addr_d;
    y_q         <= y_d;
    mask_q      <= mask_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign pixel_x_o         = out_x_q;
  assign pixel_y_o         = out_y_q;
  assign pixel_color_o     = out_color_q;
  assign last_o            = out_last_q;
  assign stat_o.busy       = (state_q != S_IDLE);
  assign stat_o.pend_valid = pend_valid_q;

endmodule

// ===== sv/bitmap_text_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_renderer
// Bitmap font character generator with an APB register port.
// ----------------------------------------------------------------------------
// Items enter a two-deep command queue and are carried out one at a time by
// the sequencer. A row load, origin set, newline or space is carried out as
// the sequencer takes it from the queue. A drawn glyph goes through these
// steps: the sequencer takes the command, folds the start row into the store,
// then for every row does a registered read of the single-port glyph store,
// latches it, emits each pixel of the row and steps to the next row, and at
// the end flushes the final pixel; emitting and flushing wait out any output
// stall. Each pixel block corner is held back one step so that the final one
// of a glyph carries last. The glyph store is not cleared by reset; rows must
// be loaded before they are drawn.
// ----------------------------------------------------------------------------
module bitmap_text_renderer #(
  parameter int GLYPH_ROWS = btr_pkg::GLYPH_ROWS_DEF,
  parameter int NUM_GLYPHS = btr_pkg::NUM_GLYPHS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [btr_pkg::PADDR_W-1:0]         paddr,
  input  logic [btr_pkg::PDATA_W-1:0]         pwdata,
  output logic [btr_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          mode_i,
  input  logic [7:0]                          char_code_i,
  input  logic [btr_pkg::ROW_IDX_W-1:0]       row_index_i,
  input  logic [7:0]                          row_bits_i,
  input  logic signed [btr_pkg::COORD_W-1:0]  origin_x_i,
  input  logic signed [btr_pkg::COORD_W-1:0]  origin_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [btr_pkg::COORD_W-1:0]  pixel_x_o,
  output logic signed [btr_pkg::COORD_W-1:0]  pixel_y_o,
  output logic [7:0]                          pixel_color_o,
  output logic                                last_o
);

  localparam int STORE_DEPTH = NUM_GLYPHS * GLYPH_ROWS;

  btr_pkg::cfg_t              cfg_q, cfg_d;
  btr_pkg::cmd_t              cmd;
  btr_pkg::back_stat_t        stat;
  logic                       cmd_valid;
  logic                       cmd_pop;
  logic                       cfg_we;
  logic [2:0]                 reg_idx;
  logic [btr_pkg::COORD_W-1:0] px, py;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        btr_pkg::REG_SCALE:     cfg_d.scale    = pwdata[3:0];
        btr_pkg::REG_INK_COLOR: cfg_d.ink      = pwdata[7:0];
        btr_pkg::REG_ADVANCE_X: cfg_d.adv_x    = pwdata[7:0];
        btr_pkg::REG_ADVANCE_Y: cfg_d.adv_y    = pwdata[7:0];
        btr_pkg::REG_TOP_SKIP:  cfg_d.top_skip = pwdata[2:0];
        btr_pkg::REG_MIRRORED:  cfg_d.mirrored = pwdata[0];
        btr_pkg::REG_ROWS:      cfg_d.rows     = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      btr_pkg::REG_SCALE:     prdata[3:0] = cfg_q.scale;
      btr_pkg::REG_INK_COLOR: prdata[7:0] = cfg_q.ink;
      btr_pkg::REG_ADVANCE_X: prdata[7:0] = cfg_q.adv_x;
      btr_pkg::REG_ADVANCE_Y: prdata[7:0] = cfg_q.adv_y;
      btr_pkg::REG_TOP_SKIP:  prdata[2:0] = cfg_q.top_skip;
      btr_pkg::REG_MIRRORED:  prdata[0]   = cfg_q.mirrored;
      btr_pkg::REG_ROWS:      prdata[3:0] = cfg_q.rows;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale    <= btr_pkg::SCALE_RST;
      cfg_q.ink      <= btr_pkg::INK_RST;
      cfg_q.adv_x    <= btr_pkg::ADVANCE_X_RST;
      cfg_q.adv_y    <= btr_pkg::ADVANCE_Y_RST;
      cfg_q.top_skip <= btr_pkg::TOP_SKIP_RST;
      cfg_q.mirrored <= btr_pkg::MIRRORED_RST;
      cfg_q.rows     <= btr_pkg::ROWS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  btr_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  btr_back #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (px),
    .pixel_y_o     (py),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o),
    .stat_o        (stat)
  );

  assign pixel_x_o = $signed(px);
  assign pixel_y_o = $signed(py);

  // The sequencer only takes a command from the queue when it has one
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // No new command is taken while a glyph is being drawn
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !cmd_pop)
    else $error("command popped while drawing");

  // A held-back pixel never survives the end of its glyph
  a_pend_in_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pend_valid |-> stat.busy)
    else $error("pending pixel outside a glyph");

endmodule

// ===== verif/btr_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_pixel_checker
// Watches the register port and both beat channels of the bitmap text
// renderer. Keeps its own glyph store, cursor and register copies, works out
// the pixel blocks each accepted command should draw and compares every
// output beat with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module btr_pixel_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [btr_pkg::PADDR_W-1:0]        paddr,
  input  logic [btr_pkg::PDATA_W-1:0]        pwdata,
  input  logic                               pready,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         mode_i,
  input  logic [7:0]                         char_code_i,
  input  logic [btr_pkg::ROW_IDX_W-1:0]      row_index_i,
  input  logic [7:0]                         row_bits_i,
  input  logic [btr_pkg::COORD_W-1:0]        origin_x_i,
  input  logic [btr_pkg::COORD_W-1:0]        origin_y_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [btr_pkg::COORD_W-1:0]        pixel_x_i,
  input  logic [btr_pkg::COORD_W-1:0]        pixel_y_i,
  input  logic [7:0]                         pixel_color_i,
  input  logic                               last_i,
  output int                                 fail_count_o,
  output int                                 pixels_due_o
);
  import btr_pkg::*;

  localparam int STORE_DEPTH = GLYPH_ROWS_DEF * NUM_GLYPHS_DEF;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [7:0]         color;
    logic               last;
  } pixel_t;

  logic [7:0]         glyph_rows [STORE_DEPTH];
  logic [COORD_W-1:0] line_x, line_y, cur_x, cur_y;
  cfg_t               regs;
  pixel_t             pixel_fifo [$];

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  task automatic check_beat();
    pixel_t want;
    if (pixel_fifo.size() == 0) begin
      $error("unexpected pixel beat at x=%0d y=%0d", pixel_x_i, pixel_y_i);
      fail_count_o++;
    end else begin
      want = pixel_fifo.pop_front();
      check_field("pixel_x", want.x, pixel_x_i);
      check_field("pixel_y", want.y, pixel_y_i);
      check_field("pixel_color", {8'd0, want.color}, {8'd0, pixel_color_i});
      check_field("last", {15'd0, want.last}, {15'd0, last_i});
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
    case (idx)
      REG_SCALE:     regs.scale    = data[3:0];
      REG_INK_COLOR: regs.ink      = data[7:0];
      REG_ADVANCE_X: regs.adv_x    = data[7:0];
      REG_ADVANCE_Y: regs.adv_y    = data[7:0];
      REG_TOP_SKIP:  regs.top_skip = data[2:0];
      REG_MIRRORED:  regs.mirrored = data[0];
      REG_ROWS:      regs.rows     = data[3:0];
      default: ;
    endcase
  endtask

  // Pixels are held back one step so the final block of a glyph gets last.
  task automatic render_item(input logic [1:0] in_mode, input logic [7:0] code,
                             input logic [ROW_IDX_W-1:0] idx, input logic [7:0] bits,
                             input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy);
    int     n_rows;
    int     base;
    int     yy;
    int     xx;
    logic [7:0] row;
    logic   dot;
    pixel_t px;
    pixel_t held;
    bit     have_held;
    case (in_mode)
      MODE_LOAD: glyph_rows[idx] = bits;
      MODE_ORIGIN: begin
        line_x = ox;
        cur_x  = ox;
        line_y = oy;
        cur_y  = oy;
      end
      MODE_DRAW: begin
        if (code == CODE_NEWLINE) begin
          line_y = line_y + regs.scale * regs.adv_y;
          cur_x  = line_x;
          cur_y  = line_y;
        end else begin
          if (code != CODE_SPACE) begin
            n_rows    = (regs.rows > GLYPH_ROWS_DEF) ? GLYPH_ROWS_DEF : regs.rows;
            base      = code * regs.rows + regs.top_skip;
            have_held = 1'b0;
            for (yy = 0; yy < n_rows; yy++) begin
              row = glyph_rows[(base + yy) % STORE_DEPTH];
              for (xx = 0; xx < 8; xx++) begin
                dot = regs.mirrored ? row[xx] : row[7-xx];
                if (dot) begin
                  px.x     = COORD_W'(cur_x + regs.scale * xx);
                  px.y     = COORD_W'(cur_y + regs.scale * yy);
                  px.color = regs.ink;
                  px.last  = 1'b0;
                  if (have_held) pixel_fifo.push_back(held);
                  held      = px;
                  have_held = 1'b1;
                end
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              pixel_fifo.push_back(held);
            end
          end
          cur_x = cur_x + regs.scale * regs.adv_x;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      line_x        = '0;
      line_y        = '0;
      cur_x         = '0;
      cur_y         = '0;
      regs.scale    = SCALE_RST;
      regs.ink      = INK_RST;
      regs.adv_x    = ADVANCE_X_RST;
      regs.adv_y    = ADVANCE_Y_RST;
      regs.top_skip = TOP_SKIP_RST;
      regs.mirrored = MIRRORED_RST;
      regs.rows     = ROWS_RST;
      pixel_fifo.delete();
    end else begin
      // compare before predicting: a command accepted now cannot be on the output yet
      if (out_valid_i && out_ready_i) check_beat();
      if (psel && penable && pwrite && pready) write_reg(paddr[PADDR_W-1:2], pwdata);
      if (in_valid_i && in_ready_i)
        render_item(mode_i, char_code_i, row_index_i, row_bits_i, origin_x_i, origin_y_i);
    end
    pixels_due_o = pixel_fifo.size();
  end

endmodule

// ===== verif/tb_bitmap_text_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_text_renderer
// Drives glyph loads, origin sets and character draws into the renderer
// through a series of register setups and idle patterns; the pixel checker
// beside the block predicts and compares every pixel beat.
// ----------------------------------------------------------------------------
module tb_bitmap_text_renderer;
  import btr_pkg::*;

  localparam int          STORE_DEPTH   = GLYPH_ROWS_DEF * NUM_GLYPHS_DEF;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int          GLYPH_RANDOM  = 0;
  localparam int          GLYPH_EMPTY   = 1;
  localparam int          GLYPH_FULL    = 2;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int          SETTLE_CYCLES = 200;

  logic                 clk;
  logic                 rst_n;
  logic                 psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata, prdata;
  logic                 in_valid, in_ready;
  logic [1:0]           mode;
  logic [7:0]           char_code;
  logic [ROW_IDX_W-1:0] row_index;
  logic [7:0]           row_bits;
  logic signed [COORD_W-1:0] origin_x, origin_y;
  logic                 out_valid, out_ready;
  logic signed [COORD_W-1:0] pixel_x, pixel_y;
  logic [7:0]           pixel_color;
  logic                 last;

  int  mismatches;
  int  pixels_due;
  bit  written [STORE_DEPTH];
  int  cur_rows;
  int  cur_skip;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  beats_sent;
  bit  drain_failed;

  bitmap_text_renderer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .char_code_i   (char_code),
    .row_index_i   (row_index),
    .row_bits_i    (row_bits),
    .origin_x_i    (origin_x),
    .origin_y_i    (origin_y),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_o        (last)
  );

  btr_pixel_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .mode_i        (mode),
    .char_code_i   (char_code),
    .row_index_i   (row_index),
    .row_bits_i    (row_bits),
    .origin_x_i    (origin_x),
    .origin_y_i    (origin_y),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .pixel_color_i (pixel_color),
    .last_i        (last),
    .fail_count_o  (mismatches),
    .pixels_due_o  (pixels_due)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with valid still high so the next beat can follow back to back.
  task automatic send_beat(input logic [1:0] m, input logic [7:0] code,
                           input logic [ROW_IDX_W-1:0] idx, input logic [7:0] bits,
                           input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    mode      = m;
    char_code = code;
    row_index = idx;
    row_bits  = bits;
    origin_x  = ox;
    origin_y  = oy;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (m != MODE_UNUSED) beats_sent++;
  endtask

  task automatic load_row(input logic [ROW_IDX_W-1:0] idx, input logic [7:0] bits);
    send_beat(MODE_LOAD, 8'($urandom), idx, bits, COORD_W'($urandom), COORD_W'($urandom));
    written[idx] = 1'b1;
  endtask

  // Loads rows a draw reads if unwritten, for empty/full or by chance, then draws.
  task automatic draw_glyph(input logic [7:0] code, input int style);
    int n_rows;
    int base;
    int y;
    logic [ROW_IDX_W-1:0] a;
    if (code != CODE_NEWLINE && code != CODE_SPACE) begin
      n_rows = (cur_rows > GLYPH_ROWS_DEF) ? GLYPH_ROWS_DEF : cur_rows;
      base   = code * cur_rows + cur_skip;
      for (y = 0; y < n_rows; y++) begin
        a = ROW_IDX_W'(base + y);
        if (style != GLYPH_RANDOM || !written[a] || $urandom_range(3) == 0)
          load_row(a, (style == GLYPH_FULL) ? 8'hff :
                      (style == GLYPH_EMPTY) ? 8'h00 : 8'($urandom_range(255)));
      end
    end
    send_beat(MODE_DRAW, code, ROW_IDX_W'($urandom), 8'($urandom),
              COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic drain();
    int waited;
    in_valid = 1'b0;
    waited   = 0;
    while (pixels_due != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pixels_due != 0) begin
      $error("%0d pixel beats never arrived", pixels_due);
      drain_failed = 1'b1;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_ROWS) cur_rows = value[3:0];
    if (idx == REG_TOP_SKIP) cur_skip = value[2:0];
  endtask

  task automatic apply_setup(input int scale, input int ink, input int adv_x,
                             input int adv_y, input int skip, input int mirror,
                             input int rows);
    drain();
    write_reg(REG_SCALE, scale);
    write_reg(REG_INK_COLOR, ink);
    write_reg(REG_ADVANCE_X, adv_x);
    write_reg(REG_ADVANCE_Y, adv_y);
    write_reg(REG_TOP_SKIP, skip);
    write_reg(REG_MIRRORED, mirror);
    write_reg(REG_ROWS, rows);
  endtask

  task automatic run_phase(input int n_beats, input int idle_pct, input int stall_pct);
    int target;
    int pick;
    int shape;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target         = beats_sent + n_beats;
    while (beats_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        shape = $urandom_range(9);
        draw_glyph(8'($urandom_range(255)), (shape == 0) ? GLYPH_EMPTY :
                                            (shape == 1) ? GLYPH_FULL : GLYPH_RANDOM);
      end else if (pick < 70) begin
        send_beat(MODE_DRAW, CODE_SPACE, ROW_IDX_W'($urandom), 8'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
      end else if (pick < 80) begin
        send_beat(MODE_DRAW, CODE_NEWLINE, ROW_IDX_W'($urandom), 8'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
      end else if (pick < 87) begin
        send_beat(MODE_ORIGIN, 8'($urandom), ROW_IDX_W'($urandom), 8'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
      end else if (pick < 95) begin
        load_row(ROW_IDX_W'($urandom_range(STORE_DEPTH - 1)), 8'($urandom));
      end else begin
        send_beat(MODE_UNUSED, 8'($urandom), ROW_IDX_W'($urandom), 8'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] edge_rows [8];
    int i;
    edge_rows      = '{8'hff, 8'h80, 8'h01, 8'h00, 8'haa, 8'h55, 8'h33, 8'hcc};
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    mode           = MODE_LOAD;
    char_code      = '0;
    row_index      = '0;
    row_bits       = '0;
    origin_x       = '0;
    origin_y       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    beats_sent     = 0;
    drain_failed   = 1'b0;
    cur_rows       = ROWS_RST;
    cur_skip       = TOP_SKIP_RST;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: coordinate wrap at the extremes, last glyph of the store,
    // space, newline, the unused mode and an all-blank glyph.
    send_beat(MODE_ORIGIN, 8'd0, '0, 8'd0, 16'd32760, 16'h8000);
    for (i = 0; i < 8; i++) load_row(ROW_IDX_W'(STORE_DEPTH - 8 + i), edge_rows[i]);
    send_beat(MODE_DRAW, 8'd255, '0, 8'd0, '0, '0);
    send_beat(MODE_DRAW, CODE_SPACE, '1, 8'hff, '1, '1);
    send_beat(MODE_DRAW, CODE_NEWLINE, '0, 8'd0, '0, '0);
    send_beat(MODE_UNUSED, 8'hff, '1, 8'hff, '1, '1);
    send_beat(MODE_ORIGIN, 8'd0, '0, 8'd0, 16'h7fff, 16'h7ff8);
    draw_glyph(8'd0, GLYPH_EMPTY);
    send_beat(MODE_DRAW, 8'd255, '0, 8'd0, '0, '0);

    apply_setup(1, 255, 8, 8, 0, 0, 8);
    run_phase(60, 0, 0);
    apply_setup(2, 0, 0, 255, 7, 1, 8);
    run_phase(60, 75, 0);
    apply_setup(8, 8'h5a, 255, 0, 3, 0, 1);
    run_phase(60, 0, 75);
    // scale zero stacks every block on the cursor; 15 rows reads past the store end
    apply_setup(0, 128, 9, 10, 0, 1, 15);
    run_phase(60, 34, 34);
    apply_setup(15, 1, 1, 1, 5, 0, 0);
    run_phase(30, 34, 34);
    apply_setup(3, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(7), 1, $urandom_range(1, 8));
    hold_req = 1'b1;
    run_phase(70, 0, 0);
    apply_setup($urandom_range(1, 8), $urandom_range(255), $urandom_range(255),
                $urandom_range(255), $urandom_range(7), 0, $urandom_range(1, 8));
    run_phase(60, 34, 34);
    drain();

    if (mismatches == 0 && !drain_failed)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
